>>> rtl/grpc_pkg.sv
// Shared types, constants and code functions of the grey row run coder.
package grpc_pkg;

    localparam int PIXEL_W     = 8;
    localparam int COUNT_W     = 12;
    localparam int VALUE_W     = 13;
    localparam int LENGTH_W    = 5;
    localparam int RESID_W     = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 24;

    // One classified pixel: the codes it causes, run code first
    typedef struct packed {
        logic                 emit_run;
        logic                 emit_res;
        logic [VALUE_W-1:0]   run_value;
        logic [RESID_W-1:0]   res_value;
    } job_t;

    // Queue fill state seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Zigzag-mapped residual of x against pred, plus one
    function automatic logic [RESID_W-1:0] resid_code(input logic [PIXEL_W-1:0] x,
                                                      input logic [PIXEL_W-1:0] pred);
        logic [PIXEL_W-1:0] diff;
        if (x >= pred) begin
            diff = x - pred;
            return {diff, 1'b1};
        end
        diff = pred - x;
        return {diff, 1'b0};
    endfunction

    // Codeword bits: twice the leading one position, plus one
    function automatic logic [LENGTH_W-1:0] gamma_len(input logic [VALUE_W-1:0] v);
        logic [3:0] msb;
        msb = '0;
        for (int i = 1; i < VALUE_W; i++) begin
            if (v[i]) msb = 4'(i);
        end
        return {msb, 1'b1};
    endfunction

endpackage

>>> rtl/grpc_front.sv
// Front part: accepts pixels, tracks row state and classifies each pixel into a job.
module grpc_front #(
    parameter int RUN_CAP = 4095
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [grpc_pkg::S_DATA_W-1:0]       s_tdata,   // [7:0] pixel
    input  logic                                s_tlast,   // end_of_row
    input  grpc_pkg::queue_status_t             q_status,
    output logic                                push,
    output grpc_pkg::job_t                      push_job
);
    import grpc_pkg::*;

    localparam logic [COUNT_W-1:0] CAP = COUNT_W'(RUN_CAP);

    logic [PIXEL_W-1:0] prev_reg, prev_next;
    logic [PIXEL_W-1:0] prev2_reg, prev2_next;
    logic               run_reg, run_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [PIXEL_W-1:0] x;
    logic               run_eff;
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] count_inc;
    logic               accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign x        = s_tdata[PIXEL_W-1:0];

    // Classify the pixel against the two previous ones
    always_comb begin
        run_eff   = run_reg || (prev_reg == prev2_reg);
        count_eff = run_reg ? count_reg : '0;
        count_inc = (count_eff < CAP) ? count_eff + 1'b1 : count_eff;

        push_job.run_value = {1'b0, count_eff} + 1'b1;
        push_job.res_value = resid_code(x, prev_reg);
        push_job.emit_run  = 1'b0;
        push_job.emit_res  = 1'b0;
        run_next           = 1'b0;
        count_next         = count_eff;

        if (!run_eff) begin
            push_job.emit_res = 1'b1;
        end else if (x == prev_reg) begin
            run_next   = 1'b1;
            count_next = count_inc;
            if (s_tlast) begin
                push_job.emit_run  = 1'b1;
                push_job.run_value = {1'b0, count_inc} + 1'b1;
            end
        end else begin
            push_job.emit_run = 1'b1;
            push_job.emit_res = 1'b1;
        end

        if (s_tlast) begin
            prev_next  = '0;
            prev2_next = '0;
            run_next   = 1'b0;
            count_next = '0;
        end else begin
            prev_next  = x;
            prev2_next = prev_reg;
        end
    end

    assign push = accept && (push_job.emit_run || push_job.emit_res);

    // Advance row state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            prev2_reg <= '0;
            run_reg   <= 1'b0;
            count_reg <= '0;
        end else if (accept) begin
            prev_reg  <= prev_next;
            prev2_reg <= prev2_next;
            run_reg   <= run_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/grpc_queue.sv
// Short job queue between the front and back parts.
module grpc_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  grpc_pkg::job_t          push_job,
    input  logic                    pop,
    output grpc_pkg::job_t          head_job,
    output grpc_pkg::queue_status_t status
);
    import grpc_pkg::*;

    job_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] fill_reg, fill_next;
    logic                do_push, do_pop;

    assign status.full  = (fill_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/grpc_back.sv
// Back part: turns queued jobs into gamma code items through an output register.
module grpc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  grpc_pkg::job_t                    head_job,
    input  grpc_pkg::queue_status_t           q_status,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [grpc_pkg::M_DATA_W-1:0]     m_tdata,   // [12:0] gamma_value, [17:13] gamma_length
    output logic                              m_tuser,   // is_run_code
    output logic                              m_tlast    // last_of_item
);
    import grpc_pkg::*;

    logic                 valid_reg, valid_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [LENGTH_W-1:0]  length_reg, length_next;
    logic                 run_code_reg, run_code_next;
    logic                 last_reg, last_next;
    logic                 phase_reg, phase_next;
    logic                 load;
    logic                 two_codes;
    logic                 take_run;

    assign load      = !q_status.empty && (!valid_reg || m_tready);
    assign two_codes = head_job.emit_run && head_job.emit_res;
    assign take_run  = head_job.emit_run && !(two_codes && phase_reg);

    // Pick the next code of the head job
    always_comb begin
        valid_next    = valid_reg && !m_tready;
        value_next    = value_reg;
        length_next   = length_reg;
        run_code_next = run_code_reg;
        last_next     = last_reg;
        phase_next    = phase_reg;
        pop           = 1'b0;
        if (load) begin
            valid_next    = 1'b1;
            run_code_next = take_run;
            value_next    = take_run ? head_job.run_value
                                     : {{(VALUE_W-RESID_W){1'b0}}, head_job.res_value};
            length_next   = gamma_len(value_next);
            if (two_codes && !phase_reg) begin
                last_next  = 1'b0;
                phase_next = 1'b1;
            end else begin
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Hold the code payload until taken
    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        length_reg   <= length_next;
        run_code_reg <= run_code_next;
        last_reg     <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W-VALUE_W-LENGTH_W){1'b0}}, length_reg, value_reg};
    assign m_tuser  = run_code_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/grey_row_predictive_run_coder.sv
// Top level of the grey row run coder: front, job queue and back.
//
//  channel  dir  payload                                   marks
//  s_       in   tdata[7:0] pixel                          tlast end_of_row
//  m_       out  tdata[12:0] gamma_value, [17:13] length   tuser is_run_code, tlast last_of_item
//
// A pixel is taken every cycle while the four-entry job queue has room.
// The back part sends one code per cycle while m_ is ready and a job waits; a break gives two codes.
// A code passes the job queue and then the output register after its pixel; m_ stalls delay it more.
// Synchronous active-low reset clears row state, queue and output valid.
// Either side may stall; the queue and the output register decouple them.
module grey_row_predictive_run_coder #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [grpc_pkg::S_DATA_W-1:0]       s_tdata,   // [7:0] pixel
    input  logic                                s_tlast,   // end_of_row
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [grpc_pkg::M_DATA_W-1:0]       m_tdata,   // [12:0] gamma_value, [17:13] gamma_length
    output logic                                m_tuser,   // is_run_code
    output logic                                m_tlast    // last_of_item
);
    import grpc_pkg::*;

    localparam int RUN_CAP = (MAX_ROW_WIDTH - 1 < 4095) ? MAX_ROW_WIDTH - 1 : 4095;

    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head_job;
    queue_status_t q_status;

    grpc_front #(
        .RUN_CAP (RUN_CAP)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    grpc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    grpc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A run code that is not last is followed at once by its residual code
    a_run_then_resid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && !m_tuser && m_tlast)
        else $error("run code not followed by residual code");

    // Residual codes stay within nine bits
    a_resid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[12:9] == 4'd0)
        else $error("residual code out of range");

    // Codeword length is always odd
    a_len_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13])
        else $error("even codeword length");

    // Nothing is pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !push)
        else $error("job pushed into full queue");

endmodule

>>> bench/tb_grey_row_predictive_run_coder.sv
// Self-checking bench for the grey row run coder: predicted gamma codes vs. the m_ stream.
`timescale 1ns / 100ps

module tb_grey_row_predictive_run_coder;

    localparam int RUN_CAP     = 4095;
    localparam int MAX_REPORTS = 10;

    // One gamma code as seen on the m_ channel
    typedef struct packed {
        logic [12:0] value;
        logic [4:0]  bits;
        logic        run_code;
        logic        last;
    } gamma_code_t;

    // Row state copy that turns accepted pixels into awaited codes
    class row_code_predictor;
        logic [7:0]  prev_pix;
        logic [7:0]  prev2_pix;
        bit          run_mode;
        int          run_len;
        gamma_code_t awaited_codes[$];
        int          bad_codes;

        function new();
            clear_row();
            bad_codes = 0;
        endfunction

        function void clear_row();
            prev_pix  = '0;
            prev2_pix = '0;
            run_mode  = 1'b0;
            run_len   = 0;
        endfunction

        // Codeword bits: leading zeros, then the binary value
        function int codeword_bits(int v);
            int n;
            n = 0;
            while (v > 1) begin
                v = v >> 1;
                n++;
            end
            return 2 * n + 1;
        endfunction

        function int zigzag(int x, int pred);
            if (x >= pred)
                return 2 * (x - pred);
            return 2 * (pred - x) - 1;
        endfunction

        function gamma_code_t make_code(int v, bit is_run);
            gamma_code_t c;
            c.value    = 13'(v);
            c.bits     = 5'(codeword_bits(v));
            c.run_code = is_run;
            c.last     = 1'b0;
            return c;
        endfunction

        function void take_pixel(logic [7:0] pix, logic eor);
            gamma_code_t made[2];
            int          n;
            logic [7:0]  w;
            logic [7:0]  ww;
            n  = 0;
            w  = prev_pix;
            ww = prev2_pix;
            // enter run mode when the two previous pixels agree
            if (!run_mode && w == ww) begin
                run_mode = 1'b1;
                run_len  = 0;
            end
            if (!run_mode) begin
                made[n++] = make_code(zigzag(pix, w) + 1, 1'b0);
            end else if (pix == w) begin
                if (run_len < RUN_CAP) run_len++;
            end else begin
                made[n++] = make_code(run_len + 1, 1'b1);
                made[n++] = make_code(zigzag(pix, w) + 1, 1'b0);
                run_mode  = 1'b0;
            end
            // close the row, flushing an open run
            if (eor) begin
                if (run_mode) made[n++] = make_code(run_len + 1, 1'b1);
                clear_row();
            end else begin
                prev2_pix = w;
                prev_pix  = pix;
            end
            for (int i = 0; i < n; i++) begin
                if (i == n - 1) made[i].last = 1'b1;
                awaited_codes.push_back(made[i]);
            end
        endfunction

        function void match_code(gamma_code_t got);
            gamma_code_t want;
            if (awaited_codes.size() == 0) begin
                bad_codes++;
                if (bad_codes <= MAX_REPORTS)
                    $display("unexpected code: value %0d bits %0d run %0b last %0b",
                             got.value, got.bits, got.run_code, got.last);
                return;
            end
            want = awaited_codes.pop_front();
            if (got !== want) begin
                bad_codes++;
                if (bad_codes <= MAX_REPORTS)
                    $display({"code mismatch: want value %0d bits %0d run %0b last %0b,",
                              " got value %0d bits %0d run %0b last %0b"},
                             want.value, want.bits, want.run_code, want.last,
                             got.value, got.bits, got.run_code, got.last);
            end
        endfunction

        function int outstanding();
            return awaited_codes.size();
        endfunction
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [grpc_pkg::S_DATA_W-1:0] s_tdata  = '0;   // [7:0] pixel
    logic                          s_tlast  = 1'b0; // end_of_row
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [grpc_pkg::M_DATA_W-1:0] m_tdata;         // [12:0] gamma_value, [17:13] gamma_length
    logic                          m_tuser;         // is_run_code
    logic                          m_tlast;         // last_of_item

    row_code_predictor coder_model = new();
    bit                src_calm    = 1'b0;

    grey_row_predictive_run_coder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("grey_row_predictive_run_coder: mismatch");
        $finish;
    end

    // Mostly short gaps, a few long ones, none while calm
    function int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Note accepted pixels first, then check accepted codes
    always @(posedge aclk) begin
        gamma_code_t got;
        if (aresetn && s_tvalid && s_tready)
            coder_model.take_pixel(s_tdata[7:0], s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            got.value    = m_tdata[12:0];
            got.bits     = m_tdata[17:13];
            got.run_code = m_tuser;
            got.last     = m_tlast;
            coder_model.match_code(got);
        end
    end

    // Code sink: random stalls with calm stretches
    initial begin
        int hold_left;
        int r;
        bit sink_calm;
        hold_left = 0;
        sink_calm = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= 1'b1;
                r = $urandom_range(0, 999);
                if (r < 4) sink_calm = !sink_calm;
                else if (!sink_calm && r < 250) hold_left = pick_gap(1'b0);
            end
            @(posedge aclk);
        end
    end

    // Offer one pixel and hold it until taken
    task automatic send_pixel(input logic [7:0] pix, input logic eor);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= eor;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_row(input logic [7:0] pixels[$]);
        for (int i = 0; i < pixels.size(); i++)
            send_pixel(pixels[i], i == pixels.size() - 1);
    endtask

    // Long flat row: grow a long run, end it by a break or by row end
    task automatic send_flat_row(input logic [7:0] level, input int reps, input logic [7:0] tail);
        src_calm = 1'b1;
        for (int i = 0; i < reps; i++)
            send_pixel(level, 1'b0);
        send_pixel(tail, 1'b1);
        src_calm = 1'b0;
    endtask

    // Random rows, mostly short, biased to runs and small steps
    task automatic send_random_rows(input int target);
        int         sent;
        int         row_len;
        int         mode;
        logic [7:0] pix;
        logic [7:0] last_pix;
        sent = 0;
        while (sent < target) begin
            row_len  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                    : $urandom_range(1, 24);
            src_calm = ($urandom_range(0, 3) == 0);
            last_pix = '0;
            for (int i = 0; i < row_len; i++) begin
                mode = $urandom_range(0, 99);
                if (mode < 45)
                    pix = last_pix;
                else if (mode < 70)
                    pix = last_pix + 8'($urandom_range(0, 6)) - 8'd3;
                else
                    pix = 8'($urandom);
                send_pixel(pix, i == row_len - 1);
                last_pix = pix;
                sent++;
            end
        end
        src_calm = 1'b0;
    endtask

    initial begin
        int wait_left;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // run from row start, break to full scale, residual extremes, rejoin a run
        send_row('{8'd0, 8'd0, 8'd255, 8'd0, 8'd128, 8'd128, 8'd128});
        // single-pixel rows: flat and maximal break
        send_row('{8'd0});
        send_row('{8'd255});
        // run entered mid-row, broken on the last pixel
        send_row('{8'd7, 8'd3, 8'd200, 8'd201, 8'd201, 8'd201, 8'd0});
        // immediate break from row start, then a negative residual
        send_row('{8'd1, 8'd0});

        // long runs, flushed at row end and at a break
        send_flat_row(8'd0, 300, 8'd0);
        send_flat_row(8'd5, 301, 8'd9);

        send_random_rows(1270);
        s_tvalid <= 1'b0;

        // drain, then allow a short quiet window for stray codes
        while (coder_model.outstanding() > 0) @(posedge aclk);
        wait_left = 20;
        while (wait_left > 0) begin
            @(posedge aclk);
            wait_left--;
        end

        if (coder_model.bad_codes == 0 && coder_model.outstanding() == 0) begin
            $display("grey_row_predictive_run_coder: match");
        end else begin
            $display("grey_row_predictive_run_coder: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/grpc_pkg.sv
rtl/grpc_front.sv
rtl/grpc_queue.sv
rtl/grpc_back.sv
rtl/grey_row_predictive_run_coder.sv
bench/tb_grey_row_predictive_run_coder.sv
